// ----- hdl/mhpq_pkg.sv -----
// Package for the min-heap priority queue: sizes, codes, beat types and key helpers.
// Used by mhpq_cell and min_heap_priority_queue; depends on nothing else.
package mhpq_pkg;

    // Storage sizing.
    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // Fixed field widths of the channel beats.
    localparam int KEY_FIELD_BITS = 32;
    localparam int ENTRY_BITS     = 7;

    // Key width actually taken from the input field, and the shift that sign-extends it.
    localparam int KEY_EFF_BITS = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
    localparam int KEY_SHIFT    = KEY_FIELD_BITS - KEY_EFF_BITS;

    typedef logic signed [KEY_BITS-1:0]       key_t;
    typedef logic [CNT_BITS-1:0]              cnt_t;
    typedef logic signed [KEY_FIELD_BITS-1:0] key_field_t;

    // Command codes.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Key returned by an extract on an empty queue: -1.0 in Q16.16.
    localparam key_field_t EMPTY_KEY = 32'shFFFF0000;

    // Capacity as a count value.
    localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

    typedef struct packed {
        logic       cmd;
        key_field_t key_in;
    } cmd_item_t;

    typedef struct packed {
        key_field_t              key_out;
        logic [1:0]              status;
        logic [ENTRY_BITS-1:0]   entry_count;
    } rsp_item_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic ext;
        key_t key;
    } cell_ctrl_t;

    // Sign-extend the low effective bits of an input key to the stored width.
    function automatic key_t widen_key(input key_field_t raw);
        key_field_t t;
        t = (raw <<< KEY_SHIFT) >>> KEY_SHIFT;
        return key_t'(t);
    endfunction

endpackage

// ----- hdl/mhpq_cell.sv -----
// One cell of the sorted key chain: holds a single key and trades with its neighbors.
// Depends on mhpq_pkg for the key and control types.
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_gt,
    input  key_t       left_key,
    input  key_t       right_key,
    output logic       gt,
    output key_t       key
);

    key_t key_reg;
    key_t key_next;

    // An empty cell counts as greater than any key, so new keys land there.
    assign gt  = !occupied || (key_reg > ctrl.key);
    assign key = key_reg;

    // Insert shifts the greater tail right by one; extract shifts everything left.
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins && gt)
        begin
            key_next = left_gt ? left_key : ctrl.key;
        end
        else if (ctrl.ext)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ----- hdl/min_heap_priority_queue.sv -----
// Top level of the bounded min-priority queue over signed Q16.16 keys.
// Depends on mhpq_pkg and instantiates a chain of mhpq_cell.
//
// The queue keeps its keys in a chain of CAPACITY cells held in ascending order, so the
// smallest key always sits in the first cell. An insert finds its place by a compare in
// every cell at once and shifts the greater keys one cell to the right, and an extract
// shifts the whole chain one cell to the left. The result beat appears in an output
// register on the cycle after the command is accepted, so the queue sustains one command
// per cycle while the result side is not stalled. The command side stalls only while a
// finished result is held because the result side is stalled. Duplicate keys are
// kept; an insert into a full queue and an extract from an empty one leave the contents
// unchanged and report their status.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    cnt_t       count_reg;
    cnt_t       count_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    rsp_item_t  rsp_item_reg;
    rsp_item_t  rsp_item_next;

    logic       accept;
    logic       do_ins;
    logic       do_ext;
    cell_ctrl_t ctrl;

    logic [CAPACITY-1:0] cell_gt;
    key_t                cell_key [CAPACITY];

    // A new command beat is taken unless a held result is still stalled.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign do_ins = accept && (cmd_item.cmd == CMD_INSERT) && (count_reg != CAP_CNT);
    assign do_ext = accept && (cmd_item.cmd == CMD_EXTRACT) && (count_reg != '0);

    assign ctrl.ins = do_ins;
    assign ctrl.ext = do_ext;
    assign ctrl.key = widen_key(cmd_item.key_in);

    // The sorted chain of key cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic occupied;
        logic left_gt;
        key_t left_key;
        key_t right_key;

        assign occupied = cnt_t'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign left_gt  = 1'b0;
            assign left_key = ctrl.key;
        end
        else
        begin : g_inner
            assign left_gt  = cell_gt[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_body
            assign right_key = cell_key[i+1];
        end

        mhpq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .left_gt   (left_gt),
            .left_key  (left_key),
            .right_key (right_key),
            .gt        (cell_gt[i]),
            .key       (cell_key[i])
        );
    end

    // Entry count and the result beat.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (do_ext)
        begin
            count_next = count_reg - cnt_t'(1);
        end

        rsp_item_next.key_out     = '0;
        rsp_item_next.status      = ST_OK;
        rsp_item_next.entry_count = ENTRY_BITS'(count_next);
        if (cmd_item.cmd == CMD_INSERT)
        begin
            if (count_reg == CAP_CNT)
            begin
                rsp_item_next.status = ST_FULL;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                rsp_item_next.key_out = EMPTY_KEY;
                rsp_item_next.status  = ST_EMPTY;
            end
            else
            begin
                rsp_item_next.key_out = KEY_FIELD_BITS'(cell_key[0]);
            end
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef ASSERT_OFF
    // The count never runs past the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count exceeds capacity");

    // An extract from a non-empty queue removes exactly one key.
    a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_item.cmd == CMD_EXTRACT && count_reg != '0)
        |=> (count_reg == $past(count_reg) - cnt_t'(1)))
        else $error("extract did not drop the count by one");

    // The first two cells stay in ascending order, so the head is the minimum.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= cnt_t'(2)) |-> !(cell_key[1] < cell_key[0]))
        else $error("head of the chain is not the smallest key");

    // An empty status always reports an empty queue.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_item_reg.status == ST_EMPTY)
        |-> (rsp_item_reg.entry_count == '0))
        else $error("empty status with a nonzero count");

    // An accepted command always produces a result beat on the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted command produced no result");
`endif

endmodule

// ----- verif/tb_min_heap_priority_queue.sv -----
// Self-checking testbench for min_heap_priority_queue: directed and random insert/extract beats
// under random idling on both channels, checked against a heap kept in the testbench.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.
module tb_min_heap_priority_queue
    import mhpq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1925;

    // Mirror of the queue contents; it predicts every result beat and checks the DUT against it.
    class heap_tracker;
        key_t        slots[CAPACITY];
        int unsigned held;
        rsp_item_t   awaited_rsp[$];
        int unsigned mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // Keep the low KEY_BITS bits of the field (at most 32) and sign-extend them.
        function key_t take_key(key_field_t raw);
            key_field_t  v;
            int unsigned eff;
            eff = (KEY_BITS < 32) ? KEY_BITS : 32;
            for (int b = 0; b < 32; b++)
            begin
                v[b] = (b < eff) ? raw[b] : raw[eff-1];
            end
            return key_t'(v);
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            key_t t;
            t = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        // A new key climbs while its parent is strictly greater.
        function void sift_up(int unsigned pos);
            int unsigned parent;
            while (pos != 0)
            begin
                parent = (pos - 1) / 2;
                if (!(slots[pos] < slots[parent]))
                    break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        // The root sinks toward the smaller child; the left child wins a tie.
        function void sift_down(int unsigned pos);
            int unsigned lc;
            int unsigned rc;
            int unsigned best;
            forever
            begin
                lc = 2 * pos + 1;
                rc = lc + 1;
                best = pos;
                if (lc < held && slots[lc] < slots[pos])
                    best = lc;
                if (rc < held && slots[rc] < slots[best])
                    best = rc;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        // Apply one command to the mirror and return the result beat it must produce.
        function rsp_item_t heap_step(cmd_item_t c);
            rsp_item_t r;
            r.key_out = '0;
            r.status  = ST_OK;
            if (c.cmd == CMD_INSERT)
            begin
                if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    slots[held] = take_key(c.key_in);
                    held++;
                    sift_up(held - 1);
                end
            end
            else if (held == 0)
            begin
                r.key_out = EMPTY_KEY;
                r.status  = ST_EMPTY;
            end
            else
            begin
                r.key_out = key_field_t'(slots[0]);
                held--;
                if (held != 0)
                begin
                    slots[0] = slots[held];
                    sift_down(0);
                end
            end
            r.entry_count = held[ENTRY_BITS-1:0];
            return r;
        endfunction

        function void note_command(cmd_item_t c);
            awaited_rsp.push_back(heap_step(c));
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("result beat with no command outstanding: key_out %0d status %0d count %0d",
                       got.key_out, got.status, got.entry_count);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.key_out !== want.key_out)
            begin
                $error("key_out: expected %0d, got %0d", want.key_out, got.key_out);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_item = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    // When set, both sides run without idle cycles.
    bit calm = 1'b0;

    heap_tracker tracker = new();

    min_heap_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Clock generation.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Present one command beat after a random idle gap and hold it until accepted.
    task automatic send_command(input logic cmd, input key_field_t key);
        int unsigned gap;
        cmd_item_t   beat;
        gap = calm ? 0 : $urandom_range(0, 4);
        beat.cmd = cmd;
        beat.key_in = key;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= beat;
        do @(posedge clk); while (cmd_stall);
        tracker.note_command(beat);
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (tracker.awaited_rsp.size() != 0);
    endtask

    // Keys: full-range values, a narrow band that makes duplicates, extremes and small Q16.16.
    function automatic key_field_t pick_key();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9)) inside
            [0:3]:      return key_field_t'(r);
            [4:5]:      return key_field_t'($urandom_range(0, 15)) - 8;
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFFFFFF;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000000;
                    default: return EMPTY_KEY;
                endcase
            end
            default:    return key_field_t'({{13{r[18]}}, r[18:0]});
        endcase
    endfunction

    // Reset, directed beats, random phases, then the final verdict.
    initial
    begin
        int unsigned sent;
        int unsigned span;
        int unsigned insert_pct;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty extract, extract of the only key, extremes, duplicates, full drain.
        send_command(CMD_EXTRACT, 32'sh00000000);
        send_command(CMD_INSERT,  32'sh00000000);
        send_command(CMD_EXTRACT, 32'sh00000000);
        send_command(CMD_INSERT,  32'sh7FFFFFFF);
        send_command(CMD_INSERT,  32'sh80000000);
        send_command(CMD_INSERT,  32'sh00010000);
        send_command(CMD_INSERT,  EMPTY_KEY);
        send_command(CMD_INSERT,  32'shFFFFFFFF);
        send_command(CMD_INSERT,  32'sh00000000);
        send_command(CMD_INSERT,  32'sh80000000);
        send_command(CMD_INSERT,  32'sh00010000);
        send_command(CMD_EXTRACT, 32'shFFFFFFFF);
        repeat (7) send_command(CMD_EXTRACT, 32'sh55555555);
        send_command(CMD_EXTRACT, 32'sh7FFFFFFF);
        send_command(CMD_INSERT,  32'sh00000005);
        send_command(CMD_INSERT,  32'sh00000005);
        send_command(CMD_INSERT,  32'sh00000003);
        send_command(CMD_EXTRACT, 32'shAAAAAAAA);
        send_command(CMD_EXTRACT, 32'sh00000000);
        wait_for_results();

        // Random phases: filling (reaches full), draining (reaches empty) and balanced.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0)
            begin
                span = 200;
                insert_pct = 88;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 88;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                span = $urandom_range(60, 200);
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++)
            begin
                send_command(($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_EXTRACT,
                             pick_key());
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
        end

        // Let the last results drain, then keep waiting to catch stray beats.
        cmd_valid <= 1'b0;
        while (tracker.awaited_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.awaited_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: stall for a random number of cycles, then take and check one beat.
    initial
    begin
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 4);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            tracker.check_response(rsp_item);
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
